// ----- hdl/rcfru_pkg.sv -----
// Package for the remote-control frame unpacker: word types and frame constants.
// No dependencies; used by the interfaces, the decoder and the top level.
`default_nettype none

package rcfru_pkg;

  // Bytes kept per frame; later bytes are only counted.
  localparam int unsigned NumStored = 15;
  localparam int unsigned PosWidth  = 5;
  localparam int unsigned IdxWidth  = 4;

  // Bytes per complete frame (valid range 15 to 31).
  localparam logic [PosWidth-1:0] FrameLength = 5'd18;
  localparam logic [PosWidth-1:0] LastPos     = FrameLength - 5'd1;

  localparam logic [7:0] GapLimitReset = 8'd1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] arrival_ms;
  } in_word_t;

  typedef struct packed {
    logic [10:0]        right_x;
    logic [10:0]        right_y;
    logic [10:0]        left_x;
    logic [10:0]        left_y;
    logic [1:0]         left_switch;
    logic [1:0]         right_switch;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [7:0]         press_left;
    logic [7:0]         press_right;
    logic [7:0]         key_bits;
  } frame_t;

endpackage

`default_nettype wire

// ----- hdl/rcfru_if.sv -----
// Valid/ready channel interfaces for the frame unpacker: received bytes in, frames out.
// Depends on rcfru_pkg for the word types.
`default_nettype none

interface rcfru_in_if;
  logic                valid;
  logic                ready;
  rcfru_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcfru_out_if;
  logic              valid;
  logic              ready;
  rcfru_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/rcfru_decode.sv -----
// Field extraction from the 15 stored frame bytes into one decoded frame.
// Depends on rcfru_pkg.
`default_nettype none

module rcfru_decode (
  input  rcfru_pkg::byte_t  bytes_i [rcfru_pkg::NumStored],
  output rcfru_pkg::frame_t frame_o
);
  import rcfru_pkg::*;

  always_comb begin
    frame_o.right_x      = {bytes_i[1][2:0], bytes_i[0]};
    frame_o.right_y      = {bytes_i[2][5:0], bytes_i[1][7:3]};
    frame_o.left_x       = {bytes_i[4][0], bytes_i[3], bytes_i[2][7:6]};
    frame_o.left_y       = {bytes_i[5][3:0], bytes_i[4][7:1]};
    frame_o.left_switch  = bytes_i[5][7:6];
    frame_o.right_switch = bytes_i[5][5:4];
    // mouse axes are little-endian
    frame_o.mouse_x      = {bytes_i[7], bytes_i[6]};
    frame_o.mouse_y      = {bytes_i[9], bytes_i[8]};
    frame_o.mouse_z      = {bytes_i[11], bytes_i[10]};
    frame_o.press_left   = bytes_i[12];
    frame_o.press_right  = bytes_i[13];
    frame_o.key_bits     = bytes_i[14];
  end

endmodule

`default_nettype wire

// ----- hdl/rc_frame_receiver_unpacker.sv -----
// Top level of the remote-control frame unpacker: framing, byte store, result register.
// Depends on rcfru_pkg, rcfru_in_if / rcfru_out_if and rcfru_decode.
//
// Usage
//   in_i  : one word per received serial byte, with its millisecond arrival tick.
//   out_o : one decoded frame word after every FrameLength-th byte of a frame.
//   cfg   : cfg_we_i / cfg_wdata_i write the inter-byte gap limit (ms); write
//           only while no frame is in flight.
//   A byte whose wrapped signed gap to the previous byte exceeds the limit
//   restarts the frame at position 0; the arrival tick is kept for every byte.
// Timing
//   One byte per cycle sustained while in_i.ready holds (see Stall). A completed
//   frame appears on out_o in the cycle after its last byte is taken, held in the result register.
//   The work per byte is a 32-bit subtract, negate and compare plus one store
//   write, all between the input handshake and the result register.
// Stall
//   While a frame waits on out_o, bytes keep flowing until the position reaches
//   the last byte of a frame, where the next byte may finish another frame;
//   there in_i.ready drops until out_o.ready is seen, even for a resync byte.
// Reset
//   Position and last arrival clear to zero, gap limit to 1, no frame pending.
//   The byte store is not cleared: every byte is rewritten before it is read.
`default_nettype none

module rc_frame_receiver_unpacker (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  rcfru_in_if.sink       in_i,
  rcfru_out_if.source    out_o
);
  import rcfru_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         last_q;
  logic [7:0]          limit_q;
  byte_t               frame_q [NumStored];
  logic                out_valid_q;
  frame_t              out_q;

  logic                in_acc;
  logic [31:0]         gap_raw;
  logic [31:0]         gap_mag;
  logic                resync;
  logic [PosWidth-1:0] pos_eff;
  logic [PosWidth-1:0] pos_inc;
  logic                store_en;
  logic [IdxWidth-1:0] wr_idx;
  logic                frame_done;
  byte_t               bytes_cur [NumStored];
  frame_t              frame_dec;

  // Only a byte at the last position can finish a frame; a resync sends it
  // to position 0, so stalling on that position alone is enough.
  assign in_i.ready = !out_valid_q || out_o.ready || (pos_q != LastPos);
  assign in_acc     = in_i.valid && in_i.ready;

  // wrapped signed gap, magnitude
  assign gap_raw = in_i.data.arrival_ms - last_q;
  assign gap_mag = gap_raw[31] ? (~gap_raw + 32'd1) : gap_raw;
  assign resync  = gap_mag > {24'd0, limit_q};

  assign pos_eff    = resync ? '0 : pos_q;
  assign pos_inc    = pos_eff + 5'd1;
  assign store_en   = in_acc && (pos_eff < PosWidth'(NumStored));
  assign wr_idx     = pos_eff[IdxWidth-1:0];
  assign frame_done = pos_inc == FrameLength;

  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      pos_d = frame_done ? '0 : pos_inc;
    end
  end

  // Frame view with the current byte merged in, so a frame whose last
  // stored byte arrives now decodes correctly.
  for (genvar k = 0; k < NumStored; k++) begin : g_merge
    assign bytes_cur[k] = (store_en && wr_idx == IdxWidth'(k)) ? in_i.data.data_byte
                                                                : frame_q[k];
  end

  rcfru_decode u_decode (
    .bytes_i (bytes_cur),
    .frame_o (frame_dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      last_q      <= '0;
      limit_q     <= GapLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (in_acc) begin
        last_q <= in_i.data.arrival_ms;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_acc && frame_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      frame_q[wr_idx] <= in_i.data.data_byte;
    end
    if (in_acc && frame_done) begin
      out_q <= frame_dec;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Position never reaches the frame length; it wraps to zero instead.
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < FrameLength)
    else $error("frame position out of range");

  // A byte that finishes a frame leaves position 0 and a pending frame.
  a_frame_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_done) |=> (pos_q == '0) && out_valid_q)
    else $error("finished frame not emitted");

  // Bytes taken under an output stall never disturb the pending frame.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_q && !out_o.ready) |=> out_valid_q && $stable(out_q))
    else $error("pending frame overwritten during stall");

  // A large gap always restarts the frame: the byte lands at position 0, so the position moves to 1.
  a_resync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && resync) |=> pos_q == 5'd1)
    else $error("resync did not restart frame");

endmodule

`default_nettype wire

// ----- tb/rcfru_frame_checker.sv -----
// Frame checker for the remote-control frame unpacker: watches both channels and the
// gap-limit port, predicts each frame and compares it field by field.
// Depends on rcfru_pkg and the rcfru_in_if / rcfru_out_if interfaces.
`default_nettype none

module rcfru_frame_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [7:0]   cfg_wdata_i,
  rcfru_in_if               in_mon,
  rcfru_out_if              out_mon,
  output int unsigned       frames_due_o,
  output int unsigned       frames_checked_o,
  output int unsigned       fail_count_o
);
  import rcfru_pkg::*;

  byte_t                stored [NumStored];
  logic [PosWidth-1:0]  pos;
  logic [31:0]          prev_ms;
  logic [7:0]           gap_limit;
  frame_t               frames_owed [$];

  initial begin
    frames_due_o     = 0;
    frames_checked_o = 0;
    fail_count_o     = 0;
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (fail_count_o < 10) begin
        $display("check: frame %0d %s expected %0h got %0h",
                 frames_checked_o, name, want, got);
      end
      fail_count_o++;
    end
  endtask

  // Sampled mid-cycle: inputs and outputs are settled, and what is seen here is
  // what the next rising edge takes.
  always @(negedge clk_i) begin : watch
    logic [31:0] gap;
    logic [15:0] w01, w12, w45;
    logic [23:0] w234;
    frame_t      f, got;
    if (!rst_ni) begin
      pos       = '0;
      prev_ms   = '0;
      gap_limit = GapLimitReset;
      frames_owed.delete();
    end else begin
      if (cfg_we_i) begin
        gap_limit = cfg_wdata_i;
      end

      if (in_mon.valid && in_mon.ready) begin
        gap = in_mon.data.arrival_ms - prev_ms;
        if (gap[31]) begin
          gap = -gap;
        end
        if (gap > {24'd0, gap_limit}) begin
          pos = '0;
        end
        prev_ms = in_mon.data.arrival_ms;
        if (pos < NumStored) begin
          stored[pos] = in_mon.data.data_byte;
        end
        pos = pos + 1'b1;
        if (pos == FrameLength) begin
          pos  = '0;
          w01  = {stored[1], stored[0]};
          w12  = {stored[2], stored[1]};
          w234 = {stored[4], stored[3], stored[2]};
          w45  = {stored[5], stored[4]};
          f.right_x      = w01[10:0];
          f.right_y      = w12[13:3];
          f.left_x       = w234[16:6];
          f.left_y       = w45[11:1];
          f.left_switch  = stored[5][7:6];
          f.right_switch = stored[5][5:4];
          f.mouse_x      = {stored[7], stored[6]};
          f.mouse_y      = {stored[9], stored[8]};
          f.mouse_z      = {stored[11], stored[10]};
          f.press_left   = stored[12];
          f.press_right  = stored[13];
          f.key_bits     = stored[14];
          frames_owed.push_back(f);
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (frames_owed.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("check: unexpected frame %h", got);
          end
          fail_count_o++;
        end else begin
          f = frames_owed.pop_front();
          check_field("right_x",      f.right_x,      got.right_x);
          check_field("right_y",      f.right_y,      got.right_y);
          check_field("left_x",       f.left_x,       got.left_x);
          check_field("left_y",       f.left_y,       got.left_y);
          check_field("left_switch",  f.left_switch,  got.left_switch);
          check_field("right_switch", f.right_switch, got.right_switch);
          check_field("mouse_x",      f.mouse_x,      got.mouse_x);
          check_field("mouse_y",      f.mouse_y,      got.mouse_y);
          check_field("mouse_z",      f.mouse_z,      got.mouse_z);
          check_field("press_left",   f.press_left,   got.press_left);
          check_field("press_right",  f.press_right,  got.press_right);
          check_field("key_bits",     f.key_bits,     got.key_bits);
        end
        frames_checked_o++;
      end
    end
    frames_due_o = frames_owed.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Top of the frame unpacker testbench: clock, reset, byte stimulus, frame drain
// and verdict. Depends on rcfru_pkg, the channel interfaces, the unpacker and
// rcfru_frame_checker, which does all prediction and comparison.
`default_nettype none

module tb;
  import rcfru_pkg::*;

  // Receiver hold-off used to fill the block and stall its input.
  localparam int unsigned HoldCycles = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;

  rcfru_in_if  in_if ();
  rcfru_out_if out_if ();

  int unsigned frames_due;
  int unsigned frames_checked;
  int unsigned fail_count;

  // Stimulus state: the arrival tick of the last word sent and the gap limit
  // the block currently holds (reset value until the first write).
  logic [31:0] now_ms    = 32'd0;
  logic [7:0]  limit_now = GapLimitReset;
  int unsigned bytes_sent = 0;
  int unsigned cfg_writes = 0;
  bit          sender_gaps   = 1'b0;
  bit          receiver_gaps = 1'b0;
  bit          hold_req      = 1'b0;

  rc_frame_receiver_unpacker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  rcfru_frame_checker checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_mon           (in_if),
    .out_mon          (out_if),
    .frames_due_o     (frames_due),
    .frames_checked_o (frames_checked),
    .fail_count_o     (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte values lean on the extremes so every bit of every field flips often.
  function automatic byte_t random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // Arrival tick that keeps the frame position: gap magnitude within the limit,
  // either direction, often exactly on the limit.
  function automatic logic [31:0] near_time();
    logic [31:0] g;
    if ($urandom_range(0, 5) == 0) begin
      g = {24'd0, limit_now};
    end else begin
      g = $urandom_range(0, limit_now);
    end
    return $urandom_range(0, 1) ? now_ms + g : now_ms - g;
  endfunction

  // Arrival tick that forces a resync: one past the limit either way, the
  // half-range gap, or any random jump whose magnitude exceeds the limit.
  function automatic logic [31:0] far_time();
    logic [31:0] d, mag;
    case ($urandom_range(0, 3))
      0:       d = {24'd0, limit_now} + 32'd1;
      1:       d = -({24'd0, limit_now} + 32'd1);
      2:       d = 32'h8000_0000;
      default: begin
        d   = $urandom;
        mag = d[31] ? -d : d;
        if (mag <= {24'd0, limit_now}) begin
          d = {24'd0, limit_now} + 32'd1;
        end
      end
    endcase
    return now_ms + d;
  endfunction

  // One word on the input channel. Acceptance is judged mid-cycle, so the
  // task returns on the rising edge that took the word.
  task automatic send_byte(input byte_t b, input logic [31:0] t);
    logic took;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.data.data_byte  <= b;
    in_if.data.arrival_ms <= t;
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    now_ms = t;
    bytes_sent++;
  endtask

  // Gap limit is only changed with the block idle: input quiet, every frame
  // drained, and the result register given time to clear.
  task automatic set_gap_limit(input logic [7:0] v);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (frames_due != 0);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_now = v;
    cfg_writes++;
  endtask

  // A frame normally opens with a resync jump and keeps its gaps within the
  // limit. A broken one either stops short or resyncs part way through.
  task automatic send_frame(input bit broken);
    int unsigned cut, k;
    cut = broken ? $urandom_range(1, FrameLength - 5'd1) : FrameLength;
    send_byte(random_byte(), ($urandom_range(0, 3) == 0) ? near_time() : far_time());
    for (k = 1; k < FrameLength; k++) begin
      if (k == cut) begin
        if ($urandom_range(0, 1)) begin
          break;
        end
        send_byte(random_byte(), far_time());
      end else begin
        send_byte(random_byte(), near_time());
      end
    end
  endtask

  // Mostly clean frames with random content, some broken ones, and the odd
  // stray word at a random tick.
  task automatic run_phase(input logic [7:0] limit, input int unsigned words,
                           input bit tx_gaps, input bit rx_gaps, input bit squeeze);
    int unsigned first;
    set_gap_limit(limit);
    sender_gaps   = tx_gaps;
    receiver_gaps = rx_gaps;
    if (squeeze) begin
      hold_req = 1'b1;
    end
    first = bytes_sent;
    while (bytes_sent - first < words) begin
      case ($urandom_range(0, 9))
        7, 8:    send_frame(1'b1);
        9:       send_byte(random_byte(), $urandom);
        default: send_frame(1'b0);
      endcase
    end
  endtask

  // Frame drain. Random stall bursts, or one long hold-off on request so the
  // block fills with a waiting frame and pushes back on its input.
  initial begin : drain
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    int          k;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset limit of 1 ms: an all-ones frame whose ticks wrap
    // past zero with gaps of +1, 0 and -1, then a resync one past the limit,
    // a resync on the half-range gap and a small backwards gap.
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    t = 32'hFFFF_FFF8;
    for (k = 0; k < FrameLength; k++) begin
      send_byte(8'hFF, t);
      case (k % 5)
        3:       t = t - 32'd1;
        4:       t = t;
        default: t = t + 32'd1;
      endcase
    end
    send_byte(8'h00, now_ms + 32'd2);
    send_byte(8'h00, now_ms + 32'h8000_0000);
    send_byte(8'h00, now_ms - 32'd1);
    send_byte(8'h5A, 32'h0000_0000);

    // Random phases over several limits, the extremes among them; the squeeze
    // runs with the sender flat out, and the last phase has no idling at all.
    run_phase(8'd0,                        310, 1'b1, 1'b1, 1'b0);
    run_phase(8'd255,                      310, 1'b0, 1'b1, 1'b1);
    run_phase(8'($urandom_range(2, 254)),  310, 1'b1, 1'b0, 1'b0);
    run_phase(8'd1,                        310, 1'b0, 1'b1, 1'b0);
    run_phase(8'($urandom_range(2, 254)),  310, 1'b1, 1'b1, 1'b0);
    run_phase(8'd255,                      300, 1'b0, 1'b0, 1'b0);

    in_if.valid <= 1'b0;
    while (frames_due != 0) @(posedge clk_i);
    // Room for a stray frame to show up after the last expected one.
    repeat (5) @(posedge clk_i);

    $display("tb: %0d bytes sent, %0d frames compared, gap limit written %0d times",
             bytes_sent, frames_checked, cfg_writes);
    $display("tb: limits 0, 1, 255 and random, with wrapped ticks and stalled input");
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/rcfru_pkg.sv
hdl/rcfru_if.sv
hdl/rcfru_decode.sv
hdl/rc_frame_receiver_unpacker.sv
tb/rcfru_frame_checker.sv
tb/tb.sv
